>>> rtl/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
// Depends on nothing; imported by fpa_div, fixed_point_alu_top and the testbench.
package fpa_pkg;

   // Field widths of the request and response beats
   localparam int OP_BITS   = 4;
   localparam int RES_BITS  = 32;

   // Default number format (Q24.8)
   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 8;

   // Operation codes
   typedef enum logic [OP_BITS-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MIN      = 4'd4,
      OP_MAX      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_TO_INT   = 4'd8,
      OP_FROM_INT = 4'd9
   } op_type;

   typedef struct packed {
      logic [OP_BITS-1:0]         operation;
      logic signed [RES_BITS-1:0] operand_a;
      logic signed [RES_BITS-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [RES_BITS-1:0] result;
      logic                       a_less;
      logic                       a_equal;
      logic                       a_greater;
      logic                       divide_by_zero;
   } rsp_type;

   // Compare flags of A against B
   typedef struct packed {
      logic less;
      logic equal;
      logic greater;
   } cmp_type;

   // Everything that rides alongside the divider pipeline
   typedef struct packed {
      logic [OP_BITS-1:0]         op;
      logic signed [RES_BITS-1:0] res;
      logic                       dz;
      cmp_type                    cmp;
   } side_type;

endpackage

>>> rtl/fixed_point_alu_top.sv
// Top level of the signed fixed-point ALU.
// Depends on fpa_pkg and fpa_div.
//
// Usage:
//   A request beat (operation, operand_a, operand_b) is taken at a rising
//   edge where start is high and busy is low. busy never rises, so a new
//   beat may be offered every cycle.
//   Each request yields exactly one response beat on rsp_data, marked by
//   rsp_valid for one cycle; the receiver has no way to hold it off.
//   Each beat passes three stages of operand capture, multiply and
//   result select, then one divider stage per quotient bit, then the
//   output register; the default format is Q24.8. All operations
//   share that path, so responses keep request order.
//   Throughput is one beat per cycle; the divider is fully pipelined.
//   Synchronous reset drops all beats in flight; no response follows.
//   The block holds no state between beats.
module fixed_point_alu_top #(
   parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fpa_pkg::req_type req_data,
   output logic             rsp_valid,
   output fpa_pkg::rsp_type rsp_data
);
   import fpa_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int DW = W + F;

   assign busy = 1'b0;

   // Stage 1: capture and narrow operands
   logic                 s1_valid_ff;
   logic [OP_BITS-1:0]   s1_op_ff;
   logic signed [W-1:0]  s1_a_ff, s1_b_ff;
   logic signed [W-1:0]  a_in, b_in;

   assign a_in = signed'(req_data.operand_a[W-1:0]);
   assign b_in = signed'(req_data.operand_b[W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= req_data.operation;
      s1_a_ff  <= a_in;
      s1_b_ff  <= b_in;
   end

   // Stage 2: full product, compare flags
   logic                  s2_valid_ff;
   logic [OP_BITS-1:0]    s2_op_ff;
   logic signed [W-1:0]   s2_a_ff, s2_b_ff;
   logic signed [2*W-1:0] s2_prod_ff;
   cmp_type               s2_cmp_ff;
   cmp_type               cmp_in;

   always_comb begin
      cmp_in.less    = s1_a_ff < s1_b_ff;
      cmp_in.equal   = s1_a_ff == s1_b_ff;
      cmp_in.greater = s1_a_ff > s1_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff   <= s1_op_ff;
      s2_a_ff    <= s1_a_ff;
      s2_b_ff    <= s1_b_ff;
      s2_prod_ff <= (2*W)'(s1_a_ff) * (2*W)'(s1_b_ff);
      s2_cmp_ff  <= cmp_in;
   end

   // Stage 3: non-divide results, divider operand prep
   logic                 s3_valid_ff;
   side_type             s3_side_ff;
   logic [DW-1:0]        s3_num_ff;
   logic [W-1:0]         s3_den_ff;
   logic                 s3_neg_ff;
   logic signed [W-1:0]  res_w;
   logic [W-1:0]         abs_a, abs_b;
   side_type             side_in;

   always_comb begin
      case (s2_op_ff)
         OP_ADD:      res_w = s2_a_ff + s2_b_ff;
         OP_SUB:      res_w = s2_a_ff - s2_b_ff;
         OP_MUL:      res_w = signed'(s2_prod_ff[F+W-1:F]);
         OP_MIN:      res_w = s2_cmp_ff.greater ? s2_b_ff : s2_a_ff;
         OP_MAX:      res_w = s2_cmp_ff.less ? s2_b_ff : s2_a_ff;
         OP_INC:      res_w = s2_a_ff + W'(1);
         OP_DEC:      res_w = s2_a_ff - W'(1);
         OP_TO_INT:   res_w = s2_a_ff >>> F;
         OP_FROM_INT: res_w = s2_a_ff << F;
         default:     res_w = '0;
      endcase
      abs_a       = s2_a_ff[W-1] ? W'(-s2_a_ff) : W'(s2_a_ff);
      abs_b       = s2_b_ff[W-1] ? W'(-s2_b_ff) : W'(s2_b_ff);
      side_in.op  = s2_op_ff;
      side_in.res = RES_BITS'(res_w);
      side_in.dz  = (s2_op_ff == OP_DIV) && (s2_b_ff == '0);
      side_in.cmp = s2_cmp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_side_ff <= side_in;
      s3_num_ff  <= DW'(abs_a) << F;
      s3_den_ff  <= abs_b;
      s3_neg_ff  <= s2_a_ff[W-1] ^ s2_b_ff[W-1];
   end

   // Divider pipeline, sideband travels with it
   logic                dv_valid;
   logic signed [W-1:0] dv_quo;
   side_type            dv_side;

   fpa_div #(
      .WORD_BITS(W),
      .FRAC_BITS(F)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_neg    (s3_neg_ff),
      .in_side   (s3_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      if (dv_side.op == OP_DIV) begin
         rsp_data_in.result = dv_side.dz ? '0 : RES_BITS'(dv_quo);
      end else begin
         rsp_data_in.result = dv_side.res;
      end
      rsp_data_in.a_less         = dv_side.cmp.less;
      rsp_data_in.a_equal        = dv_side.cmp.equal;
      rsp_data_in.a_greater      = dv_side.cmp.greater;
      rsp_data_in.divide_by_zero = dv_side.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on fpa_pkg (side_type).
module fpa_div #(
   parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [WORD_BITS+FRAC_BITS-1:0]    in_num,
   input  logic [WORD_BITS-1:0]              in_den,
   input  logic                              in_neg,
   input  fpa_pkg::side_type                 in_side,
   output logic                              out_valid,
   output logic signed [WORD_BITS-1:0]       out_quo,
   output fpa_pkg::side_type                 out_side
);
   import fpa_pkg::*;

   localparam int DW = WORD_BITS + FRAC_BITS;

   // Per-stage registers
   logic                 valid_ff [DW];
   logic [WORD_BITS-1:0] rem_ff   [DW];
   logic [DW-1:0]        nq_ff    [DW];
   logic [WORD_BITS-1:0] den_ff   [DW];
   logic                 neg_ff   [DW];
   side_type             side_ff  [DW];

   genvar i;
   generate
      for (i = 0; i < DW; i++) begin : g_stage
         logic                 valid_prev;
         logic [WORD_BITS-1:0] rem_prev;
         logic [DW-1:0]        nq_prev;
         logic [WORD_BITS-1:0] den_prev;
         logic                 neg_prev;
         side_type             side_prev;
         logic [WORD_BITS:0]   trial;
         logic [WORD_BITS:0]   diff;
         logic                 ge;
         logic [WORD_BITS-1:0] rem_in;
         logic [DW-1:0]        nq_in;

         if (i == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = '0;
            assign nq_prev    = in_num;
            assign den_prev   = in_den;
            assign neg_prev   = in_neg;
            assign side_prev  = in_side;
         end else begin : g_next
            assign valid_prev = valid_ff[i-1];
            assign rem_prev   = rem_ff[i-1];
            assign nq_prev    = nq_ff[i-1];
            assign den_prev   = den_ff[i-1];
            assign neg_prev   = neg_ff[i-1];
            assign side_prev  = side_ff[i-1];
         end

         // Shift in next dividend bit, trial subtract
         always_comb begin
            trial  = {rem_prev, nq_prev[DW-1]};
            diff   = trial - {1'b0, den_prev};
            ge     = ~diff[WORD_BITS];
            rem_in = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            nq_in  = {nq_prev[DW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else begin
               valid_ff[i] <= valid_prev;
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[i]  <= rem_in;
            nq_ff[i]   <= nq_in;
            den_ff[i]  <= den_prev;
            neg_ff[i]  <= neg_prev;
            side_ff[i] <= side_prev;
         end
      end
   endgenerate

   // Apply sign; result wraps to the word
   assign out_valid = valid_ff[DW-1];
   assign out_quo   = neg_ff[DW-1] ? -signed'(nq_ff[DW-1][WORD_BITS-1:0])
                                   :  signed'(nq_ff[DW-1][WORD_BITS-1:0]);
   assign out_side  = side_ff[DW-1];

endmodule

>>> verif/testbench.sv
// Testbench for the fixed-point ALU: directed and random beats, self-checking.
// Depends on fpa_pkg and fixed_point_alu_top (default Q24.8 format).
`timescale 1ns / 100ps

module testbench;
   import fpa_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int LATENCY = WORD_BITS_DEF + FRAC_BITS_DEF + 4;
   localparam int WATCHDOG_LIMIT = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pending_beats[$];
   rsp_type expected_rsps[$];
   int      mismatch_count = 0;
   int      rsp_count = 0;
   int      req_count = 0;
   int      idle_cycles = 0;
   int      gap_left = 0;
   logic    stimulus_done = 1'b0;

   fixed_point_alu_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Predict one response beat from one request beat
   function automatic rsp_type alu_predict(req_type beat);
      rsp_type r;
      logic signed [31:0] a, b;
      logic signed [63:0] wide;
      a = beat.operand_a;
      b = beat.operand_b;
      r = '0;
      r.a_less = a < b;
      r.a_equal = a == b;
      r.a_greater = a > b;
      case (beat.operation)
         OP_ADD:      r.result = a + b;
         OP_SUB:      r.result = a - b;
         OP_MUL: begin
            wide = 64'(a) * 64'(b);
            wide = wide >>> FRAC;
            r.result = wide[31:0];
         end
         OP_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
               r.result = '0;
            end else begin
               wide = (64'(a) <<< FRAC) / 64'(b);
               r.result = wide[31:0];
            end
         end
         OP_MIN:      r.result = (a > b) ? b : a;
         OP_MAX:      r.result = (a < b) ? b : a;
         OP_INC:      r.result = a + 1;
         OP_DEC:      r.result = a - 1;
         OP_TO_INT:   r.result = a >>> FRAC;
         OP_FROM_INT: r.result = a << FRAC;
         default:     r.result = '0;
      endcase
      return r;
   endfunction

   // Random operand: mix of extremes, small values and full-range noise
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3, 4:    return 32'($signed($urandom_range(0, 4096)) - 2048);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_beat(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      req_type t;
      t.operation = op;
      t.operand_a = a;
      t.operand_b = b;
      return t;
   endfunction

   // Fill the queue of request beats
   initial begin
      logic [31:0] ext[4];
      logic [31:0] b;
      ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
      // every operation on extremes
      for (int op = 0; op <= OP_FROM_INT; op++)
         pending_beats.push_back(make_beat(4'(op), ext[op % 4], ext[(op + 1) % 4]));
      // equal operands, divide by zero, min/max ties, overflow, negative to-int, unused selectors
      pending_beats.push_back(make_beat(OP_DIV, 32'h100, 32'h0));
      pending_beats.push_back(make_beat(OP_DIV, 32'h8000_0000, 32'hffff_ff00));
      pending_beats.push_back(make_beat(OP_MIN, 32'h1234, 32'h1234));
      pending_beats.push_back(make_beat(OP_MAX, 32'hffff_fe00, 32'hffff_fe00));
      pending_beats.push_back(make_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000));
      pending_beats.push_back(make_beat(OP_TO_INT, 32'hffff_ff01, 32'h0));
      pending_beats.push_back(make_beat(4'd10, 32'h5, 32'h3));
      pending_beats.push_back(make_beat(4'd15, 32'hffff_ffff, 32'hffff_ffff));
      for (int i = 0; i < 500; i++) begin
         b = pick_operand();
         if ($urandom_range(0, 15) == 0) b = '0;
         pending_beats.push_back(make_beat(($urandom_range(0, 19) == 0) ?
            4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9)),
            ($urandom_range(0, 9) == 0) ? b : pick_operand(), b));
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: offer beats with random gaps, mostly short
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(alu_predict(req_data));
            req_count <= req_count + 1;
         end
         if (start && busy) begin
            // hold the beat until taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_data <= pending_beats.pop_front();
            start <= 1'b1;
            case ($urandom_range(0, 19))
               0:          gap_left <= $urandom_range(10, 60);
               1, 2, 3, 4: gap_left <= $urandom_range(1, 3);
               default:    gap_left <= 0;
            endcase
         end else begin
            start <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // Monitor: compare each response beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsps.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected response beat: %h", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display({"mismatch: expected res=%h lt=%b eq=%b gt=%b dz=%b,",
                            " got res=%h lt=%b eq=%b gt=%b dz=%b"},
                     want.result, want.a_less, want.a_equal, want.a_greater,
                     want.divide_by_zero, rsp_data.result, rsp_data.a_less,
                     rsp_data.a_equal, rsp_data.a_greater, rsp_data.divide_by_zero);
            end
         end
      end
   end

   // Watchdog on cycles without a request or response beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // End of run
   initial begin
      wait (stimulus_done && expected_rsps.size() == 0 || idle_cycles >= WATCHDOG_LIMIT);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d beats outstanding", expected_rsps.size());
         $display("fixed_point_alu_top test failed");
      end else begin
         repeat (LATENCY + 4) @(posedge clock);
         $display("%0d request beats over all operations, unused selectors and extremes;",
            req_count);
         $display("%0d response beats checked, %0d mismatches", rsp_count, mismatch_count);
         if (mismatch_count == 0)
            $display("fixed_point_alu_top test passed");
         else
            $display("fixed_point_alu_top test failed");
      end
      $finish;
   end

endmodule

>>> fixed_point_alu_top.f
rtl/fpa_pkg.sv
rtl/fpa_div.sv
rtl/fixed_point_alu_top.sv
verif/testbench.sv
